/* src/tsfe_pkg.sv */
// Shared constants, codes and types for the tar stream file extractor.
// No dependencies; every other file refers to this package by scoped names.
package tsfe_pkg;

    localparam int NAME_BYTES_DEF = 100;
    localparam int BLOCK_BYTES    = 512;
    localparam int OFFSET_W       = 9;
    localparam int SIZE_AT        = 124;
    localparam int SIZE_DIGITS    = 11;
    localparam int MAGIC_AT       = 257;
    localparam int MAGIC_LEN      = 5;
    localparam int SIZE_W         = 33;
    localparam int REM_W          = 34;
    localparam logic [7:0] ASCII_ZERO = 8'h30;

    localparam logic [1:0] KIND_KEY   = 2'd0;
    localparam logic [1:0] KIND_ARCH  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic [1:0] STATUS_DATA     = 2'd0;
    localparam logic [1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [1:0] STATUS_NOTFOUND = 2'd2;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       is_last;
    } t_result;

    function automatic logic [7:0] magic_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h75;
            3'd1:    c = 8'h73;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h61;
            3'd4:    c = 8'h72;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

/* src/tsfe_key_mem.sv */
// Key store: single write port, one registered read port with write forwarding.
// Depends on tsfe_pkg for the default depth.
module tsfe_key_mem #(
    parameter int DEPTH = tsfe_pkg::NAME_BYTES_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/tsfe_out_reg.sv */
// Result register between the parser and the output channel.
// Depends on tsfe_pkg for the result type.
module tsfe_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  tsfe_pkg::t_result i_res,
    output logic             o_free,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [7:0]       o_out_byte,
    output logic [1:0]       o_status,
    output logic             o_is_last
);

    logic              r_valid;
    tsfe_pkg::t_result r_res;

    assign o_free = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_byte  = r_res.out_byte;
    assign o_status    = r_res.status;
    assign o_is_last   = r_res.is_last;

endmodule

/* src/tsfe_core.sv */
// Input register, header parser state machine and data/skip counting.
// Depends on tsfe_pkg; drives the key store ports and the result register.
module tsfe_core #(
    parameter int NAME_BYTES = tsfe_pkg::NAME_BYTES_DEF,
    parameter int AW         = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_kind,
    input  logic [7:0]        i_byte_value,
    input  logic              i_out_free,
    input  logic [7:0]        i_key_q,
    output logic              o_key_wr_en,
    output logic [AW-1:0]     o_key_wr_addr,
    output logic [7:0]        o_key_wr_data,
    output logic              o_key_rd_en,
    output logic [AW-1:0]     o_key_rd_addr,
    output logic              o_res_valid,
    output tsfe_pkg::t_result o_res
);

    localparam int KLW = $clog2(NAME_BYTES + 1);
    localparam int OW  = tsfe_pkg::OFFSET_W;
    localparam int SW  = tsfe_pkg::SIZE_W;
    localparam int RW  = tsfe_pkg::REM_W;
    localparam logic [OW-1:0] NAME_END   = OW'(NAME_BYTES);
    localparam logic [OW-1:0] SIZE_LO    = OW'(tsfe_pkg::SIZE_AT);
    localparam logic [OW-1:0] SIZE_HI    = OW'(tsfe_pkg::SIZE_AT + tsfe_pkg::SIZE_DIGITS);
    localparam logic [OW-1:0] MAGIC_LO   = OW'(tsfe_pkg::MAGIC_AT);
    localparam logic [OW-1:0] MAGIC_HI   = OW'(tsfe_pkg::MAGIC_AT + tsfe_pkg::MAGIC_LEN);
    localparam logic [OW-1:0] BLOCK_LAST = OW'(tsfe_pkg::BLOCK_BYTES - 1);
    localparam logic [RW-1:0] BLOCK_MASK = RW'(tsfe_pkg::BLOCK_BYTES - 1);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_DATA,
        PH_SKIP,
        PH_DONE
    } t_phase;

    logic            r_a_valid;
    logic [1:0]      r_a_kind;
    logic [7:0]      r_a_byte;
    logic [KLW-1:0]  r_key_length, n_key_length;
    logic [OW-1:0]   r_block_offset, n_block_offset;
    t_phase          r_phase, n_phase;
    logic [SW-1:0]   r_size, n_size;
    logic            r_name_eq, n_name_eq;
    logic            r_name_term, n_name_term;
    logic            r_magic_ok, n_magic_ok;
    logic [RW-1:0]   r_remaining, n_remaining;
    logic            n_res_valid;
    tsfe_pkg::t_result n_res;

    logic            fire;
    logic            key_full;
    logic            name_chk;
    logic [7:0]      key_cmp;
    logic            size_hit;
    logic [SW-1:0]   size_next;
    logic            magic_hit;
    logic            magic_bad;
    logic            v_eq;
    logic            v_term;
    logic [SW-1:0]   v_size;
    logic            v_ok;
    logic            block_end;
    logic [RW-1:0]   size_up;
    logic [RW-1:0]   rem_dec;
    logic [OW-1:0]   rd_offset;

    assign fire       = r_a_valid && i_out_free;
    assign o_in_stall = r_a_valid && !i_out_free;

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_a_kind <= i_kind;
            r_a_byte <= i_byte_value;
        end
    end

    assign key_full  = r_key_length >= KLW'(NAME_BYTES);
    assign name_chk  = (r_block_offset < NAME_END) && !r_name_term;
    assign key_cmp   = (r_block_offset < OW'(r_key_length)) ? i_key_q : 8'h00;
    assign size_hit  = (r_block_offset >= SIZE_LO) && (r_block_offset < SIZE_HI);
    assign size_next = {r_size[SW-4:0], 3'b000}
                       + (SW'(r_a_byte) - SW'(tsfe_pkg::ASCII_ZERO));
    assign magic_hit = (r_block_offset >= MAGIC_LO) && (r_block_offset < MAGIC_HI);
    assign magic_bad = magic_hit
                       && (r_a_byte != tsfe_pkg::magic_char(3'(r_block_offset - MAGIC_LO)));
    assign v_eq      = r_name_eq && !(name_chk && (r_a_byte != key_cmp));
    assign v_term    = r_name_term || (name_chk && (r_a_byte == 8'h00));
    assign v_size    = size_hit ? size_next : r_size;
    assign v_ok      = r_magic_ok && !magic_bad;
    assign block_end = r_block_offset == BLOCK_LAST;
    assign size_up   = (RW'(v_size) + BLOCK_MASK) & ~BLOCK_MASK;
    assign rem_dec   = r_remaining - RW'(1);

    always_comb begin
        n_key_length   = r_key_length;
        n_block_offset = r_block_offset;
        n_phase        = r_phase;
        n_size         = r_size;
        n_name_eq      = r_name_eq;
        n_name_term    = r_name_term;
        n_magic_ok     = r_magic_ok;
        n_remaining    = r_remaining;
        n_res_valid    = 1'b0;
        n_res          = '0;
        if (fire) begin
            case (r_a_kind)
                tsfe_pkg::KIND_KEY: begin
                    if (!key_full) begin
                        n_key_length = r_key_length + KLW'(1);
                    end
                end
                tsfe_pkg::KIND_ARCH: begin
                    unique case (r_phase)
                        PH_HEADER: begin
                            n_name_eq   = v_eq;
                            n_name_term = v_term;
                            n_size      = v_size;
                            n_magic_ok  = v_ok;
                            if (!block_end) begin
                                n_block_offset = r_block_offset + OW'(1);
                            end else begin
                                n_block_offset = '0;
                                n_name_eq      = 1'b1;
                                n_name_term    = 1'b0;
                                n_size         = '0;
                                n_magic_ok     = 1'b1;
                                if (!v_ok) begin
                                    n_phase        = PH_DONE;
                                    n_res_valid    = 1'b1;
                                    n_res.status   = tsfe_pkg::STATUS_NOTFOUND;
                                    n_res.is_last  = 1'b1;
                                end else if (v_eq && (v_term || key_full)) begin
                                    if (v_size == '0) begin
                                        n_phase       = PH_DONE;
                                        n_res_valid   = 1'b1;
                                        n_res.status  = tsfe_pkg::STATUS_EMPTY;
                                        n_res.is_last = 1'b1;
                                    end else begin
                                        n_remaining = RW'(v_size);
                                        n_phase     = PH_DATA;
                                    end
                                end else begin
                                    n_remaining = size_up;
                                    n_phase     = (size_up == '0) ? PH_HEADER : PH_SKIP;
                                end
                            end
                        end
                        PH_DATA: begin
                            n_res_valid    = 1'b1;
                            n_res.out_byte = r_a_byte;
                            n_res.status   = tsfe_pkg::STATUS_DATA;
                            n_res.is_last  = r_remaining <= RW'(1);
                            n_remaining    = rem_dec;
                            if (r_remaining <= RW'(1)) begin
                                n_phase = PH_DONE;
                            end
                        end
                        PH_SKIP: begin
                            n_remaining = rem_dec;
                            if (rem_dec == '0) begin
                                n_phase = PH_HEADER;
                            end
                        end
                        PH_DONE: begin
                        end
                        default: begin
                        end
                    endcase
                end
                tsfe_pkg::KIND_CLEAR: begin
                    n_key_length   = '0;
                    n_remaining    = '0;
                    n_block_offset = '0;
                    n_phase        = PH_HEADER;
                    n_size         = '0;
                    n_name_eq      = 1'b1;
                    n_name_term    = 1'b0;
                    n_magic_ok     = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid      <= 1'b0;
            r_key_length   <= '0;
            r_block_offset <= '0;
            r_phase        <= PH_HEADER;
            r_size         <= '0;
            r_name_eq      <= 1'b1;
            r_name_term    <= 1'b0;
            r_magic_ok     <= 1'b1;
            r_remaining    <= '0;
        end else begin
            if (!o_in_stall) begin
                r_a_valid <= i_in_valid;
            end
            r_key_length   <= n_key_length;
            r_block_offset <= n_block_offset;
            r_phase        <= n_phase;
            r_size         <= n_size;
            r_name_eq      <= n_name_eq;
            r_name_term    <= n_name_term;
            r_magic_ok     <= n_magic_ok;
            r_remaining    <= n_remaining;
        end
    end

    // prefetch the key byte for the offset of the next header byte
    assign rd_offset     = i_rst_n ? n_block_offset : '0;
    assign o_key_rd_en   = rd_offset < NAME_END;
    assign o_key_rd_addr = rd_offset[AW-1:0];
    assign o_key_wr_en   = i_rst_n && fire && (r_a_kind == tsfe_pkg::KIND_KEY) && !key_full;
    assign o_key_wr_addr = r_key_length[AW-1:0];
    assign o_key_wr_data = r_a_byte;
    assign o_res_valid   = n_res_valid;
    assign o_res         = n_res;

    a_offset_header_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_HEADER) |-> (r_block_offset == '0))
        else $error("block offset left nonzero outside header phase");

    a_remaining_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_DATA) || (r_phase == PH_SKIP)) |-> (r_remaining != '0))
        else $error("data or skip phase with nothing remaining");

    a_key_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_key_length <= KLW'(NAME_BYTES))
        else $error("key length beyond name field");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.is_last) |=> (r_phase == PH_DONE))
        else $error("final beat did not end the search");

    a_result_from_archive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (fire && (r_a_kind == tsfe_pkg::KIND_ARCH)))
        else $error("result without an archive beat");

endmodule

/* src/tar_stream_file_extractor.sv */
// Finds the file named by the loaded key in a ustar archive streamed one byte
// per beat and streams its data bytes out. One beat is accepted every cycle,
// sustained, whatever the kind, while the input is not stalled; a result is
// presented from the result register after its beat passes the input register.
// An output stall holds a valid result and stalls the input once the input
// register holds a beat. No clearing pass follows reset: the key length gates
// every key read from the single key memory, prefetched for the next header byte.
module tar_stream_file_extractor #(
    parameter int NAME_BYTES = tsfe_pkg::NAME_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_byte_value,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_status,
    output logic       o_is_last
);

    localparam int AW = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;

    logic              out_free;
    logic [7:0]        key_q;
    logic              key_wr_en;
    logic [AW-1:0]     key_wr_addr;
    logic [7:0]        key_wr_data;
    logic              key_rd_en;
    logic [AW-1:0]     key_rd_addr;
    logic              res_valid;
    tsfe_pkg::t_result res;

    tsfe_key_mem #(
        .DEPTH (NAME_BYTES),
        .AW    (AW)
    ) u_key_mem (
        .i_clk     (i_clk),
        .i_wr_en   (key_wr_en),
        .i_wr_addr (key_wr_addr),
        .i_wr_data (key_wr_data),
        .i_rd_en   (key_rd_en),
        .i_rd_addr (key_rd_addr),
        .o_rd_data (key_q)
    );

    tsfe_core #(
        .NAME_BYTES (NAME_BYTES),
        .AW         (AW)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_byte_value  (i_byte_value),
        .i_out_free    (out_free),
        .i_key_q       (key_q),
        .o_key_wr_en   (key_wr_en),
        .o_key_wr_addr (key_wr_addr),
        .o_key_wr_data (key_wr_data),
        .o_key_rd_en   (key_rd_en),
        .o_key_rd_addr (key_rd_addr),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    tsfe_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (res_valid),
        .i_res       (res),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_status    (o_status),
        .o_is_last   (o_is_last)
    );

endmodule
